// ===== sv/encoder_position_p_controller_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the encoder position controller
// Concurrent checks clocked on the block clock; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ENCODER_POSITION_P_CONTROLLER_UNIT_MACROS_SVH
`define ENCODER_POSITION_P_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// check that is switched off while reset is high
`define EPC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also holds during reset
`define EPC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define EPC_ASSERT(lbl, prop, msg)
`define EPC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== sv/epc_pkg.sv =====
// ----------------------------------------------------------------------------
// epc_pkg
// Widths, codes and reset values shared by the encoder position controller.
// ----------------------------------------------------------------------------
package epc_pkg;

   localparam int ACTION_W   = 2;
   localparam int POS_W      = 32;
   localparam int GAIN_W     = 16;
   localparam int TOL_W      = 16;
   localparam int EFFORT_W   = 10;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_EDGE_A = 2'd0,
      ACT_EDGE_B = 2'd1,
      ACT_STEP   = 2'd2,
      ACT_ZERO   = 2'd3
   } action_type;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN       = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_EFFORT = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_EFFORT = 8'd3;

   localparam logic [GAIN_W-1:0]   GAIN_RESET       = 16'd256;
   localparam logic [TOL_W-1:0]    TOLERANCE_RESET  = 16'd10;
   localparam logic [EFFORT_W-1:0] MIN_EFFORT_RESET = 10'd70;
   localparam logic [EFFORT_W-1:0] MAX_EFFORT_RESET = 10'd400;

   // Q8.8 gain: fraction bits dropped from the product
   localparam int GAIN_FRAC = 8;
   // |error| at or above 2**SAT_BIT saturates for any nonzero gain,
   // since (2**18 * 1) >> 8 = 1024 exceeds any 10-bit max_effort
   localparam int SAT_BIT = EFFORT_W + GAIN_FRAC;

endpackage

// ===== sv/encoder_position_p_controller_unit.sv =====
// ----------------------------------------------------------------------------
// encoder_position_p_controller_unit
// Quadrature position counter with a proportional position controller.
// ----------------------------------------------------------------------------
//
//   channel  ports                                   handshake
//   -------  --------------------------------------  ------------------------
//   request  req_action, req_pin_level, req_target   req_valid / req_stall
//   response rsp_position, rsp_drive,                rsp_valid / rsp_stall
//            rsp_clockwise, rsp_at_target
//   csr      csr_index, csr_data                     csr_valid / csr_ready
//
// One beat per cycle while the response is not stalled; each beat is held in the
// request register, then the response register. The control math (error subtract,
// 18x16 gain multiply, clamps) sits in the one stage between those registers.
// Synchronous active-high reset clears both stages, the count, the encoder
// levels, the drive state and loads the register defaults.
// A stalled response holds; the request side stalls only when its register is
// full and cannot move into the stalled response register.
// ----------------------------------------------------------------------------
module encoder_position_p_controller_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [epc_pkg::ACTION_W-1:0]          req_action,
   input  logic                                  req_pin_level,
   input  logic signed [epc_pkg::POS_W-1:0]      req_target,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [epc_pkg::POS_W-1:0]      rsp_position,
   output logic [epc_pkg::EFFORT_W-1:0]          rsp_drive,
   output logic                                  rsp_clockwise,
   output logic                                  rsp_at_target,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [epc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [epc_pkg::CSR_DATA_W-1:0]        csr_data
);
   import epc_pkg::*;

`include "encoder_position_p_controller_unit_macros.svh"

   // ---------------------------------------------------------------- registers
   logic [GAIN_W-1:0]   gain_ff;
   logic [TOL_W-1:0]    tolerance_ff;
   logic [EFFORT_W-1:0] min_effort_ff;
   logic [EFFORT_W-1:0] max_effort_ff;

   // ---------------------------------------------------------------- state
   logic signed [POS_W-1:0] pos_ff,       pos_in;
   logic                    level_a_ff,   level_a_in;
   logic                    level_b_ff,   level_b_in;
   logic [EFFORT_W-1:0]     drive_ff,     drive_in;
   logic                    cw_ff,        cw_in;
   logic                    arrived_ff,   arrived_in;

   // request stage
   logic                    s1_valid_ff;
   action_type              s1_action_ff;
   logic                    s1_level_ff;
   logic signed [POS_W-1:0] s1_target_ff;

   // response stage
   logic                    rsp_valid_ff;
   logic signed [POS_W-1:0] rsp_position_ff;
   logic [EFFORT_W-1:0]     rsp_drive_ff;
   logic                    rsp_clockwise_ff;
   logic                    rsp_at_target_ff;

   // ---------------------------------------------------------------- flow
   logic req_fire;
   logic rsp_free;
   logic s1_fire;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && rsp_free;
   assign req_stall = s1_valid_ff && !rsp_free;
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- control math
   logic signed [POS_W:0]         delta;      // exact 33-bit error
   logic [POS_W:0]                err_mag;
   logic                          in_band;
   logic                          err_big;    // saturates for any nonzero gain
   logic [SAT_BIT+GAIN_W-1:0]     product;
   logic [SAT_BIT+GAIN_W-GAIN_FRAC-1:0] scaled;
   logic [EFFORT_W-1:0]           mag_sat;
   logic [EFFORT_W-1:0]           mag_min;
   logic [EFFORT_W-1:0]           mag_out;

   always_comb begin
      delta   = {s1_target_ff[POS_W-1], s1_target_ff} - {pos_ff[POS_W-1], pos_ff};
      err_mag = delta[POS_W] ? (POS_W+1)'(-delta) : delta;
      in_band = err_mag <= (POS_W+1)'(tolerance_ff);
      err_big = |err_mag[POS_W:SAT_BIT];
      product = (SAT_BIT+GAIN_W)'(err_mag[SAT_BIT-1:0]) * (SAT_BIT+GAIN_W)'(gain_ff);
      scaled  = product[SAT_BIT+GAIN_W-1:GAIN_FRAC];

      if (gain_ff == '0) begin
         mag_sat = '0;
      end else if (err_big || scaled > ($bits(scaled))'(max_effort_ff)) begin
         mag_sat = max_effort_ff;
      end else begin
         mag_sat = scaled[EFFORT_W-1:0];
      end

      // deadband lift, then the max clamp wins over a min set above max
      mag_min = (mag_sat != '0 && mag_sat < min_effort_ff) ? min_effort_ff : mag_sat;
      mag_out = (mag_min > max_effort_ff) ? max_effort_ff : mag_min;
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      pos_in     = pos_ff;
      level_a_in = level_a_ff;
      level_b_in = level_b_ff;
      drive_in   = drive_ff;
      cw_in      = cw_ff;
      arrived_in = arrived_ff;

      case (s1_action_ff)
         ACT_EDGE_A: begin
            level_a_in = s1_level_ff;
            pos_in     = (s1_level_ff == level_b_ff) ? pos_ff + 32'sd1 : pos_ff - 32'sd1;
         end
         ACT_EDGE_B: begin
            level_b_in = s1_level_ff;
            pos_in     = (level_a_ff == s1_level_ff) ? pos_ff - 32'sd1 : pos_ff + 32'sd1;
         end
         ACT_STEP: begin
            if (in_band) begin
               drive_in   = '0;
               cw_in      = 1'b0;
               arrived_in = 1'b1;
            end else begin
               drive_in   = mag_out;
               cw_in      = delta[POS_W] && (mag_sat != '0);
               arrived_in = 1'b0;
            end
         end
         ACT_ZERO: begin
            pos_in = '0;
         end
         default: begin
            pos_in = pos_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------- clocked
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= GAIN_RESET;
         tolerance_ff  <= TOLERANCE_RESET;
         min_effort_ff <= MIN_EFFORT_RESET;
         max_effort_ff <= MAX_EFFORT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAIN:       gain_ff       <= csr_data[GAIN_W-1:0];
            CSR_TOLERANCE:  tolerance_ff  <= csr_data[TOL_W-1:0];
            CSR_MIN_EFFORT: min_effort_ff <= csr_data[EFFORT_W-1:0];
            CSR_MAX_EFFORT: max_effort_ff <= csr_data[EFFORT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         level_a_ff   <= 1'b0;
         level_b_ff   <= 1'b0;
         drive_ff     <= '0;
         cw_ff        <= 1'b0;
         arrived_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_fire) begin
            pos_ff       <= pos_in;
            level_a_ff   <= level_a_in;
            level_b_ff   <= level_b_in;
            drive_ff     <= drive_in;
            cw_ff        <= cw_in;
            arrived_ff   <= arrived_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_action_ff <= action_type'(req_action);
         s1_level_ff  <= req_pin_level;
         s1_target_ff <= req_target;
      end
      if (s1_fire) begin
         rsp_position_ff  <= pos_in;
         rsp_drive_ff     <= drive_in;
         rsp_clockwise_ff <= cw_in;
         rsp_at_target_ff <= arrived_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_clockwise = rsp_clockwise_ff;
   assign rsp_at_target = rsp_at_target_ff;

   // ---------------------------------------------------------------- checks
   // a direction is only reported while something is driven
   `EPC_ASSERT(a_cw_needs_drive, rsp_valid_ff |-> (!rsp_clockwise_ff || rsp_drive_ff != '0), "clockwise with zero drive")
   // arrival and a running drive exclude each other
   `EPC_ASSERT(a_arrived_stopped, rsp_valid_ff |-> (!rsp_at_target_ff || rsp_drive_ff == '0), "at_target with nonzero drive")
   // a zero request clears the count in its response
   `EPC_ASSERT(a_zero_clears, (s1_fire && s1_action_ff == ACT_ZERO) |=> (rsp_position_ff == '0), "zero request left a count")
   // an encoder edge moves the count by exactly one
   `EPC_ASSERT(a_edge_step, (s1_fire && (s1_action_ff == ACT_EDGE_A || s1_action_ff == ACT_EDGE_B)) |=> ((rsp_position_ff == $past(pos_ff) + 32'sd1) || (rsp_position_ff == $past(pos_ff) - 32'sd1)), "edge moved count by more than one")
   // after reset neither the request stage nor the response stage holds a beat
   `EPC_ASSERT_ALWAYS(a_reset_empty, reset |=> (!rsp_valid_ff && !s1_valid_ff), "pipeline not empty after reset")

endmodule
